FILE: sv/b64c_pkg.sv
// b64c_pkg: shared types, codes and alphabet functions for the base64 codec
// no dependencies; imported by every module of the codec
`timescale 1ns / 1ps

package b64c_pkg;

    // direction register values
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // register map
    localparam int                 ADDR_W         = 3;
    localparam logic [ADDR_W-1:0]  ADDR_DIRECTION = ADDR_W'(0);

    // error codes carried with each result word
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_CHAR  = 2'd1;
    localparam logic [1:0] ERR_TRUNC = 2'd2;

    // character constants
    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SLASH_CHAR = 8'h2F;

    // sextet classes above the alphabet
    localparam logic [6:0] SEXT_PAD = 7'd64;
    localparam logic [6:0] SEXT_BAD = 7'd65;

    // one group of results handed from the codec to the output queue
    typedef struct packed {
        logic            emit;      // load the queue this cycle
        logic [1:0]      last_idx;  // number of words minus one
        logic [1:0]      err;
        logic [3:0][7:0] bytes;     // word 0 in bytes[0]
    } t_res_group;

    // sextet to alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] s);
        logic [7:0] w;
        w = {2'b00, s};
        if (s < 6'd26)       return w + 8'd65;
        else if (s < 6'd52)  return w + 8'd71;
        else if (s < 6'd62)  return w + 8'd252;
        else if (s == 6'd62) return PLUS_CHAR;
        else                 return SLASH_CHAR;
    endfunction

    // alphabet character to sextet, pad or bad
    function automatic logic [6:0] dec_sextet(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)      return 7'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'h47);
        else if (c >= 8'h30 && c <= 8'h39) return 7'(c + 8'h04);
        else if (c == PLUS_CHAR)           return 7'd62;
        else if (c == SLASH_CHAR)          return 7'd63;
        else if (c == PAD_CHAR)            return SEXT_PAD;
        else                               return SEXT_BAD;
    endfunction

endpackage

FILE: sv/b64c_codec.sv
// b64c_codec: group state registers and the single-pass encode/decode logic
// depends on b64c_pkg; feeds a result group to b64c_outq when an accepted word completes or ends a group
`timescale 1ns / 1ps

module b64c_codec (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_clear,
    input  logic                  i_direction,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_end_of_message,
    output b64c_pkg::t_res_group  o_group
);
    import b64c_pkg::*;

    logic [23:0] r_bits, n_bits;
    logic [1:0]  r_gc, n_gc;
    logic [1:0]  r_pc, n_pc;

    logic [23:0] enc_bits, dec_bits;
    logic [1:0]  gc_inc;
    logic [6:0]  sext;
    logic        is_bad, is_pad, err_char, complete;
    logic [5:0]  sval;
    logic [1:0]  pc_inc;
    t_res_group  grp;

    assign gc_inc = r_gc + 2'd1;

    // encode: merge the byte into the group from the top
    always_comb begin
        case (r_gc)
            2'd0:    enc_bits = r_bits | {i_data_byte, 16'h0000};
            2'd1:    enc_bits = r_bits | {8'h00, i_data_byte, 8'h00};
            default: enc_bits = r_bits | {16'h0000, i_data_byte};
        endcase
    end

    // decode: classify the character and merge its sextet
    assign sext     = dec_sextet(i_data_byte);
    assign is_bad   = (sext == SEXT_BAD);
    assign is_pad   = (sext == SEXT_PAD);
    assign err_char = is_bad || (is_pad && (r_gc < 2'd2)) || (!is_pad && (r_pc != 2'd0));
    assign sval     = is_pad ? 6'd0 : sext[5:0];
    assign pc_inc   = r_pc + {1'b0, is_pad};
    assign complete = (r_gc == 2'd3);

    always_comb begin
        case (r_gc)
            2'd0:    dec_bits = r_bits | {sval, 18'h00000};
            2'd1:    dec_bits = r_bits | {6'h00, sval, 12'h000};
            2'd2:    dec_bits = r_bits | {12'h000, sval, 6'h00};
            default: dec_bits = r_bits | {18'h00000, sval};
        endcase
    end

    // result group and next group state
    always_comb begin
        grp      = '0;
        grp.err  = ERR_OK;
        n_bits   = r_bits;
        n_gc     = r_gc;
        n_pc     = r_pc;
        if (i_direction == DIR_ENCODE) begin
            if (r_gc == 2'd2 || i_end_of_message) begin
                grp.emit     = 1'b1;
                grp.last_idx = 2'd3;
                grp.bytes[0] = enc_char(enc_bits[23:18]);
                grp.bytes[1] = enc_char(enc_bits[17:12]);
                grp.bytes[2] = (r_gc >= 2'd1) ? enc_char(enc_bits[11:6]) : PAD_CHAR;
                grp.bytes[3] = (r_gc >= 2'd2) ? enc_char(enc_bits[5:0])  : PAD_CHAR;
                n_bits = '0;
                n_gc   = 2'd0;
                n_pc   = 2'd0;
            end else begin
                n_bits = enc_bits;
                n_gc   = gc_inc;
            end
        end else begin
            if (err_char || (!complete && i_end_of_message)) begin
                grp.emit     = 1'b1;
                grp.last_idx = 2'd0;
                grp.err      = err_char ? ERR_CHAR : ERR_TRUNC;
                n_bits = '0;
                n_gc   = 2'd0;
                n_pc   = 2'd0;
            end else if (!complete) begin
                n_bits = dec_bits;
                n_gc   = gc_inc;
                n_pc   = pc_inc;
            end else begin
                grp.emit     = 1'b1;
                grp.last_idx = 2'd2 - pc_inc;
                grp.bytes[0] = dec_bits[23:16];
                grp.bytes[1] = dec_bits[15:8];
                grp.bytes[2] = dec_bits[7:0];
                n_bits = '0;
                n_gc   = 2'd0;
                n_pc   = 2'd0;
            end
        end
    end

    // group state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_bits <= '0;
            r_gc   <= 2'd0;
            r_pc   <= 2'd0;
        end else if (i_accept) begin
            r_bits <= n_bits;
            r_gc   <= n_gc;
            r_pc   <= n_pc;
        end
    end

    always_comb begin
        o_group      = grp;
        o_group.emit = grp.emit && i_accept;
    end

endmodule

FILE: sv/b64c_outq.sv
// b64c_outq: four-word result register that serialises a group word by word, holding the current word while stalled
// depends on b64c_pkg; loaded by b64c_codec, drives the result channel
`timescale 1ns / 1ps

module b64c_outq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  b64c_pkg::t_res_group  i_group,
    output logic                  o_busy,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_out_byte,
    output logic                  o_last_of_run,
    output logic [1:0]            o_error_code
);
    import b64c_pkg::*;

    logic            r_valid;
    logic [1:0]      r_idx, r_last_idx, r_err;
    logic [3:0][7:0] r_bytes;
    logic            take, take_last;

    assign take      = r_valid && !i_stall;
    assign take_last = take && (r_idx == r_last_idx);

    // a new group may enter once the final word is leaving
    assign o_busy = r_valid && !take_last;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_group.emit) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (take_last) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_group.emit) begin
            r_bytes    <= i_group.bytes;
            r_last_idx <= i_group.last_idx;
            r_err      <= i_group.err;
        end
    end

    assign o_valid       = r_valid;
    assign o_out_byte    = r_bytes[r_idx];
    assign o_last_of_run = (r_idx == r_last_idx);
    assign o_error_code  = r_err;

endmodule

FILE: sv/base64_stream_codec_core.sv
// base64_stream_codec_core: top level of the streaming base64 codec
// depends on b64c_pkg, b64c_codec and b64c_outq
`timescale 1ns / 1ps
//
// Usage
//   Input channel (i_in_valid / o_in_stall) carries one word per item: a raw
//   byte when encoding, a base64 character when decoding, plus an
//   end-of-message flag. Result channel (o_out_valid / i_out_stall) carries
//   one output byte per word with last_of_run on the final word of an item
//   and an error code (0 ok, 1 bad character, 2 message ended mid-group).
//   The direction register (APB, byte address 0, bit 0) selects encode (0)
//   or decode (1); writing it also clears the partial group. Write it only
//   while the codec is idle.
//   The first result word is valid the cycle after the item that completes
//   a group is accepted; the group then leaves one word a cycle while the
//   receiver does not stall. An item that completes no group is accepted
//   whenever the result register is not busy; that register holds one
//   group of up to four words and the next item enters as its final word
//   leaves.
//   Reset (synchronous, active low) clears the direction, the group state
//   and the result register. A stall from the receiver holds the current
//   word; the input is stalled until the held group's final word leaves.
//

module base64_stream_codec_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_end_of_message,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [7:0]                    o_out_byte,
    output logic                          o_last_of_run,
    output logic [1:0]                    o_error_code,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [b64c_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import b64c_pkg::*;

    logic       r_direction;
    logic       cfg_write, dir_write, busy, accept;
    t_res_group group;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign dir_write = cfg_write && (paddr == ADDR_DIRECTION);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= DIR_ENCODE;
        end else if (dir_write) begin
            r_direction <= pwdata[0];
        end
    end

    assign prdata = (paddr == ADDR_DIRECTION) ? {31'd0, r_direction} : 32'd0;

    // input handshake
    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;

    // codec group logic
    b64c_codec u_codec (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_clear          (dir_write),
        .i_direction      (r_direction),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_group          (group)
    );

    // result register and serialiser
    b64c_outq u_outq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_group       (group),
        .o_busy        (busy),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_error_code  (o_error_code)
    );

endmodule
